// ----- rtl/fatf_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fatf_pkg
// Shared types, codes and constants of the FLV AAC to ADTS framer.
// ============================================================================
`default_nettype none

package fatf_pkg;

    // Input and output field widths
    localparam int BYTE_W   = 8;
    localparam int TLEN_W   = 14;
    localparam int FLEN_W   = TLEN_W + 1;
    localparam int CNT_W    = 32;
    localparam int RATE_W   = 17;
    localparam int IDX_W    = 4;

    // Position within a tag saturates here
    localparam logic [TLEN_W-1:0] POS_MAX = '1;

    // Longest ADTS frame that may be emitted, and timestamp step per frame
    localparam logic [FLEN_W-1:0] MAX_FRAME_BYTES = 15'd8191;
    localparam logic [CNT_W-1:0]  TIME_STEP       = 32'd23;

    // ADTS frame length is the tag length minus 2 plus 7
    localparam logic [FLEN_W-1:0] FLEN_ADJUST = 15'd5;

    // Fixed ADTS header bytes
    localparam logic [7:0] ADTS_SYNC0 = 8'hFF;
    localparam logic [7:0] ADTS_SYNC1 = 8'hF1;
    localparam logic [7:0] ADTS_TAIL  = 8'hFC;
    localparam logic [4:0] ADTS_FULLNESS_HI = 5'h1F;
    localparam logic [2:0] HDR_LAST_STEP = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] REG_PROFILE  = 2'd0;
    localparam logic [1:0] REG_RATE     = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    localparam logic [1:0]        PROFILE_RESET  = 2'd1;
    localparam logic [RATE_W-1:0] RATE_RESET     = 17'd44100;
    localparam logic [2:0]        CHANNELS_RESET = 3'd2;

    // Command kinds passed from front to back
    localparam logic [1:0] CMD_PAYLOAD  = 2'd0;
    localparam logic [1:0] CMD_HEADER   = 2'd1;
    localparam logic [1:0] CMD_TOO_LONG = 2'd2;

    // Command queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Sample rate to ADTS frequency index
    localparam int NUM_RATES = 13;
    localparam logic [IDX_W-1:0] DEFAULT_RATE_IDX = 4'd5;
    localparam logic [RATE_W-1:0] RATE_TABLE [NUM_RATES] = '{
        17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
        17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
        17'd7350
    };

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic             last;
        logic [7:0]       hdr2;
        logic [7:0]       hdr3;
        logic [7:0]       hdr4;
        logic [7:0]       hdr5;
        logic [CNT_W-1:0] num;
        logic [CNT_W-1:0] tim;
    } cmd_t;

    function automatic logic [IDX_W-1:0] rate_index(input logic [RATE_W-1:0] hz);
        logic [IDX_W-1:0] idx;
        idx = DEFAULT_RATE_IDX;
        // scan downward so the lowest matching index wins
        for (int i = NUM_RATES - 1; i >= 0; i--)
        begin
            if (RATE_TABLE[i] == hz)
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fatf_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fatf_front
// Accepts tag bytes, tracks tag position and frame counters, and queues one
// command per byte that produces output (header, payload or length error).
// ============================================================================
`default_nettype none

module fatf_front
#(
    parameter logic [fatf_pkg::FLEN_W-1:0] MAX_FRAME_BYTES = fatf_pkg::MAX_FRAME_BYTES,
    parameter logic [fatf_pkg::CNT_W-1:0]  TIME_STEP       = fatf_pkg::TIME_STEP
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [1:0]                        cfg_index,
    input  wire [fatf_pkg::RATE_W-1:0]       cfg_data,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire [fatf_pkg::BYTE_W-1:0]       in_byte,
    input  wire [fatf_pkg::TLEN_W-1:0]       in_length,
    input  wire                              in_last,
    input  wire                              q_full,
    output logic                             push,
    output fatf_pkg::cmd_t                   push_cmd
);

    logic [fatf_pkg::TLEN_W-1:0] pos_reg, pos_next;
    logic                        drop_reg, drop_next;
    logic [fatf_pkg::CNT_W-1:0]  fc_reg, fc_next;
    logic [fatf_pkg::CNT_W-1:0]  tc_reg, tc_next;
    logic [1:0]                  profile_reg;
    logic [fatf_pkg::RATE_W-1:0] rate_reg;
    logic [2:0]                  chan_reg;

    logic                        accept;
    logic [fatf_pkg::FLEN_W-1:0] flen;
    logic [fatf_pkg::IDX_W-1:0]  rate_idx;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign flen     = {1'b0, in_length} + fatf_pkg::FLEN_ADJUST;
    assign rate_idx = fatf_pkg::rate_index(rate_reg);

    always_comb
    begin
        pos_next  = pos_reg;
        drop_next = drop_reg;
        fc_next   = fc_reg;
        tc_next   = tc_reg;
        push      = 1'b0;

        push_cmd.kind = fatf_pkg::CMD_PAYLOAD;
        push_cmd.data = in_byte;
        push_cmd.last = in_last;
        push_cmd.hdr2 = {profile_reg, rate_idx, 1'b0, chan_reg[2]};
        push_cmd.hdr3 = {chan_reg[1:0], 4'b0000, flen[12:11]};
        push_cmd.hdr4 = flen[10:3];
        push_cmd.hdr5 = {flen[2:0], fatf_pkg::ADTS_FULLNESS_HI};
        push_cmd.num  = fc_reg - 32'd1;
        push_cmd.tim  = tc_reg - TIME_STEP;

        if (accept)
        begin
            if (pos_reg == 14'd1)
            begin
                push_cmd.num = fc_reg;
                push_cmd.tim = tc_reg;
                priority if (in_byte == 8'd0)
                begin
                    // sequence header: drop the whole tag
                    drop_next = 1'b1;
                end
                else if (flen > MAX_FRAME_BYTES)
                begin
                    push          = 1'b1;
                    push_cmd.kind = fatf_pkg::CMD_TOO_LONG;
                    drop_next     = 1'b1;
                end
                else
                begin
                    push          = 1'b1;
                    push_cmd.kind = fatf_pkg::CMD_HEADER;
                    fc_next       = fc_reg + 32'd1;
                    tc_next       = tc_reg + TIME_STEP;
                end
            end
            else if (pos_reg >= 14'd2 && !drop_reg)
            begin
                push = 1'b1;
            end

            if (in_last)
            begin
                pos_next  = '0;
                drop_next = 1'b0;
            end
            else if (pos_reg != fatf_pkg::POS_MAX)
            begin
                pos_next = pos_reg + 14'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            drop_reg <= 1'b0;
            fc_reg   <= '0;
            tc_reg   <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            drop_reg <= drop_next;
            fc_reg   <= fc_next;
            tc_reg   <= tc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_reg <= fatf_pkg::PROFILE_RESET;
            rate_reg    <= fatf_pkg::RATE_RESET;
            chan_reg    <= fatf_pkg::CHANNELS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fatf_pkg::REG_PROFILE)
            begin
                profile_reg <= cfg_data[1:0];
            end
            if (cfg_index == fatf_pkg::REG_RATE)
            begin
                rate_reg <= cfg_data;
            end
            if (cfg_index == fatf_pkg::REG_CHANNELS)
            begin
                chan_reg <= cfg_data[2:0];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fatf_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fatf_queue
// Small command FIFO between the front and back parts of the framer.
// ============================================================================
`default_nettype none

module fatf_queue
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  fatf_pkg::cmd_t  push_cmd,
    input  wire             pop,
    output fatf_pkg::cmd_t  head,
    output logic            full,
    output logic            empty
);

    fatf_pkg::cmd_t             entry_reg [fatf_pkg::Q_DEPTH];
    logic [fatf_pkg::Q_AW-1:0]  wptr_reg, wptr_next;
    logic [fatf_pkg::Q_AW-1:0]  rptr_reg, rptr_next;
    logic [fatf_pkg::Q_AW:0]    count_reg, count_next;
    logic                       do_push;
    logic                       do_pop;

    assign full    = count_reg == (fatf_pkg::Q_AW + 1)'(fatf_pkg::Q_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = entry_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + (fatf_pkg::Q_AW)'(1) : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + (fatf_pkg::Q_AW)'(1) : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (fatf_pkg::Q_AW + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (fatf_pkg::Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fatf_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fatf_back
// Expands queued commands into output words: seven header bytes, one
// payload byte or one error word, through a registered output stage.
// ============================================================================
`default_nettype none

module fatf_back
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          q_empty,
    input  fatf_pkg::cmd_t               q_head,
    output logic                         pop,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [fatf_pkg::BYTE_W-1:0]  out_byte,
    output logic                         out_start,
    output logic                         out_end,
    output logic [fatf_pkg::CNT_W-1:0]   out_num,
    output logic [fatf_pkg::CNT_W-1:0]   out_tim,
    output logic                         out_too_long,
    output logic                         out_run_last
);

    logic                        valid_reg, valid_next;
    logic [2:0]                  step_reg, step_next;
    logic [fatf_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                        start_reg, start_next;
    logic                        end_reg, end_next;
    logic [fatf_pkg::CNT_W-1:0]  num_reg;
    logic [fatf_pkg::CNT_W-1:0]  tim_reg;
    logic                        too_long_reg, too_long_next;
    logic                        run_last_reg, run_last_next;

    logic                        load;
    logic                        take;
    logic                        last_word;
    logic [7:0]                  hdr_byte;

    assign load = !valid_reg || out_ready;
    assign take = load && !q_empty;

    always_comb
    begin
        unique case (step_reg)
            3'd0:    hdr_byte = fatf_pkg::ADTS_SYNC0;
            3'd1:    hdr_byte = fatf_pkg::ADTS_SYNC1;
            3'd2:    hdr_byte = q_head.hdr2;
            3'd3:    hdr_byte = q_head.hdr3;
            3'd4:    hdr_byte = q_head.hdr4;
            3'd5:    hdr_byte = q_head.hdr5;
            default: hdr_byte = fatf_pkg::ADTS_TAIL;
        endcase
    end

    always_comb
    begin
        last_word     = 1'b1;
        byte_next     = q_head.data;
        start_next    = 1'b0;
        end_next      = q_head.last;
        too_long_next = 1'b0;
        unique case (q_head.kind)
            fatf_pkg::CMD_HEADER:
            begin
                last_word  = step_reg == fatf_pkg::HDR_LAST_STEP;
                byte_next  = hdr_byte;
                start_next = step_reg == 3'd0;
                end_next   = last_word && q_head.last;
            end
            fatf_pkg::CMD_TOO_LONG:
            begin
                byte_next     = '0;
                end_next      = 1'b0;
                too_long_next = 1'b1;
            end
            default:
            begin
                byte_next = q_head.data;
            end
        endcase
        run_last_next = last_word;

        // hold the header step until the command's final word leaves
        pop        = take && last_word;
        step_next  = step_reg;
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
            step_next  = last_word ? 3'd0 : step_reg + 3'd1;
        end
        else if (load)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg     <= byte_next;
            start_reg    <= start_next;
            end_reg      <= end_next;
            num_reg      <= q_head.num;
            tim_reg      <= q_head.tim;
            too_long_reg <= too_long_next;
            run_last_reg <= run_last_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign out_start    = start_reg;
    assign out_end      = end_reg;
    assign out_num      = num_reg;
    assign out_tim      = tim_reg;
    assign out_too_long = too_long_reg;
    assign out_run_last = run_last_reg;

endmodule

`default_nettype wire

// ----- rtl/flv_aac_to_adts_framer_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// flv_aac_to_adts_framer_core
// Turns FLV AAC audio tag bodies into ADTS frames: drops the tag header and
// sequence headers, inserts a 7-byte ADTS header and passes the payload.
// ============================================================================
//
//  Channel   Dir  Word contents
//  s_axis    in   tag byte, tag length; tlast on the final tag byte
//  m_axis    out  ADTS byte, frame number, frame time; tlast = frame end
//  cfg       in   write-only register port: profile, sample rate, channels
//
//  One input byte is taken per cycle while the four-entry command queue has
//  room; a queued payload byte leaves through the registered output stage.
//  A frame header expands into seven output words through the one-word output
//  stage; the queue absorbs that while the sink keeps taking words.
//  Output backpressure stalls only the back part until the queue fills.
//  Reset clears position, drop flag, frame counters and queue; no clearing pass.
// ============================================================================
`default_nettype none

module flv_aac_to_adts_framer_core
#(
    parameter logic [fatf_pkg::FLEN_W-1:0] MAX_FRAME_BYTES = fatf_pkg::MAX_FRAME_BYTES,
    parameter logic [fatf_pkg::CNT_W-1:0]  TIME_STEP       = fatf_pkg::TIME_STEP
)
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [23:0]  s_axis_tdata,   // [7:0] tag_byte, [21:8] tag_length, [23:22] zero
    input  wire         s_axis_tlast,   // tag_last

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] out_byte, [39:8] frame_number,
                                        // [71:40] frame_time
    output logic        m_axis_tlast,   // frame_end
    output logic [2:0]  m_axis_tuser,   // [0] frame_start, [1] too_long, [2] run_last

    input  wire         cfg_we,
    input  wire [1:0]   cfg_index,
    input  wire [16:0]  cfg_data
);

    logic            q_push;
    fatf_pkg::cmd_t  q_push_cmd;
    logic            q_pop;
    fatf_pkg::cmd_t  q_head;
    logic            q_full;
    logic            q_empty;

    logic [7:0]      o_byte;
    logic [31:0]     o_num;
    logic [31:0]     o_tim;
    logic            o_start;
    logic            o_too_long;
    logic            o_run_last;

    fatf_front
    #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .TIME_STEP       (TIME_STEP)
    )
    u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata[7:0]),
        .in_length (s_axis_tdata[21:8]),
        .in_last   (s_axis_tlast),
        .q_full    (q_full),
        .push      (q_push),
        .push_cmd  (q_push_cmd)
    );

    fatf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    fatf_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .pop          (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (o_byte),
        .out_start    (o_start),
        .out_end      (m_axis_tlast),
        .out_num      (o_num),
        .out_tim      (o_tim),
        .out_too_long (o_too_long),
        .out_run_last (o_run_last)
    );

    assign m_axis_tdata = {o_tim, o_num, o_byte};
    assign m_axis_tuser = {o_run_last, o_too_long, o_start};

endmodule

`default_nettype wire

// ----- rtl/fatf_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fatf_checker
// Port-level checks on the framer output stream, bound to the top level.
// ============================================================================
`default_nettype none

module fatf_checker
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire [71:0]  m_axis_tdata,
    input  wire         m_axis_tlast,
    input  wire [2:0]   m_axis_tuser
);

    logic out_acc;

    assign out_acc = m_axis_tvalid && m_axis_tready;

    // stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // frame start is the first sync byte and never ends the run
    a_start_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && m_axis_tuser[0] |->
            m_axis_tdata[7:0] == 8'hFF && !m_axis_tuser[1] && !m_axis_tuser[2])
        else $error("bad frame start word");

    // length error word is empty, lone and not a frame end
    a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && m_axis_tuser[1] |->
            m_axis_tdata[7:0] == 8'h00 && !m_axis_tlast && m_axis_tuser[2])
        else $error("bad length error word");

    // a frame end is always the last word of its input byte
    a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && m_axis_tlast |-> m_axis_tuser[2])
        else $error("frame end without run end");

endmodule

bind flv_aac_to_adts_framer_core fatf_checker u_fatf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
